// File: hw/rtl/mhf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mhf_pkg;

  // Field widths of the channels and the configuration port.
  localparam int REQ_W   = 3;
  localparam int BEAM_W  = 16;
  localparam int LINE_W  = 9;
  localparam int POINT_W = 16;
  localparam int CAP_W   = 12;
  localparam int CFG_W   = 16;
  localparam int CNT_W   = 10;

  // Defaults for the top-level parameters.
  localparam int VHOLD_BASE_DEF = 250;
  localparam int POS_WIDTH_DEF  = 24;

  // Phase counters advance by one character per tick.
  localparam int TICK_STEP = 'h100;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TICK       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SYNC_START = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SYNC_END   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MAX_CHECK  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MIN_CHECK  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SET_LINE   = 3'd5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_DURATION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_UP_CAP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DOWN_CAP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_LINES   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MIN_LINES = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAX_LINES = 3'd7;

  // Reset values.
  localparam logic [POINT_W-1:0] SYNC_DURATION_RST   = 16'h0A00;
  localparam logic [POINT_W-1:0] SYNC_LOW_LIMIT_RST  = 16'd13567;
  localparam logic [POINT_W-1:0] SYNC_HIGH_LIMIT_RST = 16'd14081;
  localparam logic [CAP_W-1:0]   STEP_CAP_RST        = 12'd80;
  localparam logic [LINE_W-1:0]  VISIBLE_LINES_RST   = 9'd270;
  localparam logic [LINE_W-1:0]  FRAME_MIN_RST       = 9'd295;
  localparam logic [LINE_W-1:0]  FRAME_MAX_RST       = 9'd313;
  localparam logic [POINT_W-1:0] TRIGGER_RST         = 16'd13824;

endpackage

`default_nettype wire

// File: hw/rtl/mhf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one beat carries one request.
interface mhf_in_if import mhf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [BEAM_W-1:0] beam_pos;
  logic [LINE_W-1:0]        line_value;

  modport source (output valid, req_type, beam_pos, line_value, input ready);
  modport sink   (input valid, req_type, beam_pos, line_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mhf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Result channel: one beat carries the result of one request.
interface mhf_out_if import mhf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     render_enable;
  logic                     sync_peak;
  logic signed [BEAM_W-1:0] reload_pos;
  logic                     drawing_now;
  logic                     frame_done;
  logic [POINT_W-1:0]       sync_point;

  modport source (output valid, render_enable, sync_peak, reload_pos, drawing_now,
                  frame_done, sync_point, input ready);
  modport sink   (input valid, render_enable, sync_peak, reload_pos, drawing_now,
                  frame_done, sync_point, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/monitor_hsync_flywheel_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat content
// in_ch     in         req_type, beam_pos, line_value
// out_ch    out        render_enable, sync_peak, reload_pos, drawing_now,
//                      frame_done, sync_point
// cfg_*     in         write enable, register index, write data
//
// Each request's whole effect on the flywheel state is computed
// combinationally between the state registers and the result register.
// A new request is accepted every cycle while the result register is empty
// or being drained, so the block sustains one beat per clock.
// A stalled result holds the result register and blocks further requests.
// Synchronous reset restores the configuration defaults and the flywheel state.
module monitor_hsync_flywheel_top import mhf_pkg::*; #(
  parameter int VHOLD_BASE = VHOLD_BASE_DEF,
  parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  mhf_in_if.sink               in_ch,
  mhf_out_if.source            out_ch,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_W-1:0]      cfg_data
);

  // Working width for signed sums of counters and 16-bit points.
  localparam int EW = POS_WIDTH + 3;
  localparam int FW = 12;
  typedef logic signed [EW-1:0] ext_t;
  typedef logic [POS_WIDTH-1:0] pos_t;

  function automatic ext_t pext(input pos_t v);
    return ext_t'($signed(v));
  endfunction

  // Configuration registers.
  logic [POINT_W-1:0] sync_duration;
  logic [POINT_W-1:0] sync_low_limit;
  logic [POINT_W-1:0] sync_high_limit;
  logic [CAP_W-1:0]   step_up_cap;
  logic [CAP_W-1:0]   step_down_cap;
  logic [LINE_W-1:0]  visible_lines;
  logic [LINE_W-1:0]  frame_min_lines;
  logic [LINE_W-1:0]  frame_max_lines;

  // Flywheel state.
  pos_t               since_start, since_start_next;
  pos_t               since_end, since_end_next;
  pos_t               since_peak, since_peak_next;
  pos_t               start_minus_peak, start_minus_peak_next;
  pos_t               end_minus_peak, end_minus_peak_next;
  logic               peak_seen, peak_seen_next;
  logic [POINT_W-1:0] free_run_point, free_run_point_next;
  logic [POINT_W-1:0] trigger_point, trigger_point_next;
  logic [CNT_W-1:0]   drawn_line, drawn_line_next;
  logic [CNT_W-1:0]   line_count, line_count_next;
  logic               drawing, drawing_next;

  // Result register.
  logic                     out_valid;
  logic                     res_render;
  logic                     res_peak, res_peak_next;
  logic signed [BEAM_W-1:0] res_reload, res_reload_next;
  logic                     res_done, res_done_next;

  logic accept;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Tick path: counter advance and peak detection.
  pos_t             ss_inc, se_inc, sp_inc, pk_tick;
  ext_t             horz_e, tp_e, pk_e;
  logic             hit;
  logic [CNT_W-1:0] drawn_inc;

  assign horz_e    = ext_t'(in_ch.beam_pos);
  assign tp_e      = ext_t'(trigger_point);
  assign ss_inc    = since_start + pos_t'(TICK_STEP);
  assign se_inc    = since_end + pos_t'(TICK_STEP);
  assign sp_inc    = since_peak + pos_t'(TICK_STEP);
  assign hit       = horz_e >= tp_e;
  assign pk_e      = horz_e - tp_e;
  assign pk_tick   = pk_e[POS_WIDTH-1:0];
  assign drawn_inc = drawn_line + CNT_W'(1);

  // Sync-end path: free-run step and shared correction unit.
  ext_t               pk_s, ss_s, target, fr_e, err, mag, mag_clip, mag_sh, mag_min;
  ext_t               mag_cap, fr_new_e, t_sum;
  logic               late, up;
  logic [POINT_W-1:0] fr_step, trig_corr;

  assign pk_s   = pext(since_peak);
  assign ss_s   = pext(since_start);
  assign late   = pk_s >= ss_s;
  assign target = pext(since_end) - ext_t'(sync_duration);
  assign fr_e   = ext_t'(free_run_point);

  always_comb begin
    fr_step = free_run_point;
    if (late) begin
      if (target < fr_e) begin
        if (free_run_point != sync_low_limit) fr_step = free_run_point - POINT_W'(1);
      end else if (target > fr_e) begin
        if (free_run_point != sync_high_limit) fr_step = free_run_point + POINT_W'(1);
      end
    end
  end

  assign err      = late ? (pk_s - pext(end_minus_peak)) : (pext(start_minus_peak) - pk_s);
  assign up       = err < 0;
  assign mag      = up ? (ext_t'(0) - err) : err;
  assign mag_clip = (mag > ss_s) ? ss_s : mag;
  assign mag_sh   = mag_clip >>> 3;
  assign mag_min  = (mag_sh == 0) ? ext_t'(1) : mag_sh;
  assign fr_new_e = ext_t'(fr_step);

  // Cap the correction, apply it and clamp to the limit on that side.
  always_comb begin
    if (up) begin
      mag_cap = (mag_min > ext_t'(step_up_cap)) ? ext_t'(step_up_cap) : mag_min;
      t_sum   = fr_new_e + mag_cap;
      if (t_sum > ext_t'(sync_high_limit)) t_sum = ext_t'(sync_high_limit);
    end else begin
      mag_cap = (mag_min > ext_t'(step_down_cap)) ? ext_t'(step_down_cap) : mag_min;
      t_sum   = fr_new_e - mag_cap;
      if (t_sum < ext_t'(sync_low_limit)) t_sum = ext_t'(sync_low_limit);
    end
  end

  assign trig_corr = t_sum[POINT_W-1:0];

  // Frame end: reload drawn_line with minus half the lines beyond the hold base.
  logic signed [FW-1:0] fin_v, fin_half, fin_neg;
  logic                 max_hit, min_hit;

  assign fin_v    = $signed(FW'(line_count)) - $signed(FW'(VHOLD_BASE)) + $signed(FW'(1));
  assign fin_half = fin_v >>> 1;
  assign fin_neg  = $signed(FW'(0)) - fin_half;
  assign max_hit  = line_count == CNT_W'(frame_max_lines);
  assign min_hit  = line_count > CNT_W'(frame_min_lines);

  // Next-state decode for one request.
  always_comb begin
    since_start_next      = since_start;
    since_end_next        = since_end;
    since_peak_next       = since_peak;
    start_minus_peak_next = start_minus_peak;
    end_minus_peak_next   = end_minus_peak;
    peak_seen_next        = peak_seen;
    free_run_point_next   = free_run_point;
    trigger_point_next    = trigger_point;
    drawn_line_next       = drawn_line;
    line_count_next       = line_count;
    drawing_next          = drawing;
    res_peak_next         = 1'b0;
    res_reload_next       = '0;
    res_done_next         = 1'b0;
    case (in_ch.req_type)
      REQ_TICK: begin
        since_start_next = ss_inc;
        since_end_next   = se_inc;
        since_peak_next  = sp_inc;
        if (hit) begin
          peak_seen_next        = 1'b1;
          since_peak_next       = pk_tick;
          start_minus_peak_next = ss_inc - pk_tick;
          end_minus_peak_next   = se_inc - pk_tick;
          res_peak_next         = 1'b1;
          res_reload_next       = $signed(pk_e[BEAM_W-1:0] - sync_duration);
          drawn_line_next       = drawn_inc;
          line_count_next       = line_count + CNT_W'(1);
          drawing_next          = !(drawn_inc >= CNT_W'(visible_lines));
        end
      end
      REQ_SYNC_START: begin
        since_start_next = '0;
      end
      REQ_SYNC_END: begin
        since_end_next = '0;
        if (peak_seen) begin
          peak_seen_next      = 1'b0;
          free_run_point_next = fr_step;
          if (!late && err == 0) trigger_point_next = free_run_point;
          else                   trigger_point_next = trig_corr;
        end
      end
      REQ_MAX_CHECK: begin
        if (max_hit) begin
          drawn_line_next = fin_neg[CNT_W-1:0];
          line_count_next = '0;
          drawing_next    = 1'b0;
          res_done_next   = 1'b1;
        end
      end
      REQ_MIN_CHECK: begin
        if (min_hit) begin
          drawn_line_next = fin_neg[CNT_W-1:0];
          line_count_next = '0;
          drawing_next    = 1'b0;
          res_done_next   = 1'b1;
        end
      end
      REQ_SET_LINE: begin
        if (in_ch.line_value > frame_max_lines) line_count_next = CNT_W'(frame_max_lines);
        else                                    line_count_next = CNT_W'(in_ch.line_value);
      end
      default: begin
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_duration   <= SYNC_DURATION_RST;
      sync_low_limit  <= SYNC_LOW_LIMIT_RST;
      sync_high_limit <= SYNC_HIGH_LIMIT_RST;
      step_up_cap     <= STEP_CAP_RST;
      step_down_cap   <= STEP_CAP_RST;
      visible_lines   <= VISIBLE_LINES_RST;
      frame_min_lines <= FRAME_MIN_RST;
      frame_max_lines <= FRAME_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_DURATION:   sync_duration   <= cfg_data;
        REG_SYNC_LOW_LIMIT:  sync_low_limit  <= cfg_data;
        REG_SYNC_HIGH_LIMIT: sync_high_limit <= cfg_data;
        REG_STEP_UP_CAP:     step_up_cap     <= cfg_data[CAP_W-1:0];
        REG_STEP_DOWN_CAP:   step_down_cap   <= cfg_data[CAP_W-1:0];
        REG_VISIBLE_LINES:   visible_lines   <= cfg_data[LINE_W-1:0];
        REG_FRAME_MIN_LINES: frame_min_lines <= cfg_data[LINE_W-1:0];
        REG_FRAME_MAX_LINES: frame_max_lines <= cfg_data[LINE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Flywheel state update on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      since_start      <= '0;
      since_end        <= '0;
      since_peak       <= '0;
      start_minus_peak <= '0;
      end_minus_peak   <= '0;
      peak_seen        <= 1'b0;
      free_run_point   <= TRIGGER_RST;
      trigger_point    <= TRIGGER_RST;
      drawn_line       <= '0;
      line_count       <= '0;
      drawing          <= 1'b1;
    end else if (accept) begin
      since_start      <= since_start_next;
      since_end        <= since_end_next;
      since_peak       <= since_peak_next;
      start_minus_peak <= start_minus_peak_next;
      end_minus_peak   <= end_minus_peak_next;
      peak_seen        <= peak_seen_next;
      free_run_point   <= free_run_point_next;
      trigger_point    <= trigger_point_next;
      drawn_line       <= drawn_line_next;
      line_count       <= line_count_next;
      drawing          <= drawing_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_render <= (in_ch.req_type == REQ_TICK) && drawing;
      res_peak   <= res_peak_next;
      res_reload <= res_reload_next;
      res_done   <= res_done_next;
    end
  end

  // The state registers already hold the post-item flags while the result waits.
  logic               res_drawing;
  logic [POINT_W-1:0] res_point;

  always_ff @(posedge clk) begin
    if (accept) begin
      res_drawing <= drawing_next;
      res_point   <= trigger_point_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.render_enable = res_render;
  assign out_ch.sync_peak     = res_peak;
  assign out_ch.reload_pos    = res_reload;
  assign out_ch.drawing_now   = res_drawing;
  assign out_ch.frame_done    = res_done;
  assign out_ch.sync_point    = res_point;

endmodule

`default_nettype wire
